### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the key debounce event queue.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/mkdef_pkg.sv
// ----------------------------------------------------------------------------
// mkdef_pkg
// Types, constants and helpers for the multi-key debounce event queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mkdef_pkg;

  localparam int NUM_KEYS_DEF   = 13;
  localparam int FIFO_DEPTH_DEF = 16;

  localparam int FILTER_W  = 6;
  localparam int LONG_W    = 12;
  localparam int REPEAT_W  = 8;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CMD_W     = 2;
  localparam int LEVEL_W   = 13;
  localparam int CODE_W    = 6;
  localparam int FCNT_W    = 7;
  localparam int KEY_IDX_W = 5;

  localparam logic [FILTER_W-1:0] FILTER_RST = FILTER_W'(5);
  localparam logic [LONG_W-1:0]   LONG_RST   = LONG_W'(100);
  localparam logic [REPEAT_W-1:0] REPEAT_RST = REPEAT_W'(0);
  localparam logic [FCNT_W-1:0]   FCNT_RST   = FCNT_W'(5 / 2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_TIME  = 2'd0,
    REG_LONG_TIME    = 2'd1,
    REG_REPEAT_SPEED = 2'd2
  } cfg_reg_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_SCAN  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_POP2  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_LONG    = 2'd3
  } ev_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_PUSH2,
    ST_POP,
    ST_POPW,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [FCNT_W-1:0]   fc;
    logic [LONG_W-1:0]   hc;
    logic [REPEAT_W-1:0] rc;
  } key_state_t;

  localparam int KEY_STATE_W = $bits(key_state_t);

  localparam key_state_t KEY_STATE_RST = '{fc: FCNT_RST, hc: '0, rc: '0};

  typedef struct packed {
    key_state_t          st;
    logic                pressed;
    logic                push_a;
    logic                push_b;
    logic [CODE_W-1:0]   code_a;
    logic [CODE_W-1:0]   code_b;
  } key_eval_t;

  function automatic logic [CODE_W-1:0] event_code(input logic [KEY_IDX_W-1:0] k,
                                                   input ev_kind_t kind);
    logic [7:0] t;
    t = 8'(k) * 8'd3 + 8'(kind);
    return t[CODE_W-1:0];
  endfunction

endpackage

### sv/mkdef_ram.sv
// ----------------------------------------------------------------------------
// mkdef_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mkdef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/mkdef_key_eval.sv
// ----------------------------------------------------------------------------
// mkdef_key_eval
// One-key update: debounce hysteresis, press/release, long press and repeat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mkdef_key_eval (
  input  mkdef_pkg::key_state_t                  cur,
  input  logic                                   pressed_in,
  input  logic                                   level,
  input  logic [mkdef_pkg::KEY_IDX_W-1:0]        key_num,
  input  logic [mkdef_pkg::FILTER_W-1:0]         filter_time,
  input  logic [mkdef_pkg::LONG_W-1:0]           long_time,
  input  logic [mkdef_pkg::REPEAT_W-1:0]         repeat_speed,
  output mkdef_pkg::key_eval_t                   res
);

  logic [mkdef_pkg::FCNT_W-1:0]   f_lo;
  logic [mkdef_pkg::FCNT_W-1:0]   f_hi;
  logic [mkdef_pkg::LONG_W-1:0]   hc_inc;
  logic [mkdef_pkg::REPEAT_W-1:0] rc_inc;
  logic [mkdef_pkg::CODE_W-1:0]   c_press;
  logic [mkdef_pkg::CODE_W-1:0]   c_release;
  logic [mkdef_pkg::CODE_W-1:0]   c_long;
  logic [mkdef_pkg::CODE_W-1:0]   hold_code;
  logic                           press_push;
  logic                           rel_push;
  logic                           hold_push;
  mkdef_pkg::key_state_t          nxt;
  logic                           pr_next;

  assign f_lo      = {1'b0, filter_time};
  assign f_hi      = {filter_time, 1'b0};
  assign hc_inc    = cur.hc + 1'b1;
  assign rc_inc    = cur.rc + 1'b1;
  assign c_press   = mkdef_pkg::event_code(key_num, mkdef_pkg::EV_PRESS);
  assign c_release = mkdef_pkg::event_code(key_num, mkdef_pkg::EV_RELEASE);
  assign c_long    = mkdef_pkg::event_code(key_num, mkdef_pkg::EV_LONG);

  always_comb begin
    nxt        = cur;
    pr_next    = pressed_in;
    press_push = 1'b0;
    rel_push   = 1'b0;
    hold_push  = 1'b0;
    hold_code  = c_press;
    if (level) begin
      if (cur.fc < f_lo) begin
        nxt.fc = f_lo;
      end else if (cur.fc < f_hi) begin
        nxt.fc = cur.fc + 1'b1;
      end else begin
        if (!pressed_in) begin
          pr_next    = 1'b1;
          press_push = 1'b1;
        end
        if (long_time != '0) begin
          if (cur.hc < long_time) begin
            nxt.hc = hc_inc;
            if (hc_inc == long_time) begin
              hold_push = 1'b1;
              hold_code = c_long;
            end
          end else if (repeat_speed != '0) begin
            nxt.rc = rc_inc;
            if (rc_inc >= repeat_speed) begin
              nxt.rc    = '0;
              hold_push = 1'b1;
              hold_code = c_press;
            end
          end
        end
      end
    end else begin
      if (cur.fc > f_lo) begin
        nxt.fc = f_lo;
      end else if (cur.fc != '0) begin
        nxt.fc = cur.fc - 1'b1;
      end else if (pressed_in) begin
        pr_next  = 1'b0;
        rel_push = 1'b1;
      end
      nxt.hc = '0;
      nxt.rc = '0;
    end
  end

  always_comb begin
    res.st      = nxt;
    res.pressed = pr_next;
    res.push_a  = press_push | rel_push | hold_push;
    res.push_b  = press_push & hold_push;
    res.code_b  = hold_code;
    if (press_push) begin
      res.code_a = c_press;
    end else if (rel_push) begin
      res.code_a = c_release;
    end else begin
      res.code_a = hold_code;
    end
  end

endmodule

### sv/multi_key_debounce_event_fifo.sv
// ----------------------------------------------------------------------------
// multi_key_debounce_event_fifo
// Debounces NUM_KEYS key levels per scan request, queues press, release,
// long-press and repeat codes into a ring with two readers and a clear.
// ----------------------------------------------------------------------------
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------
//   in       | in_valid / in_ready    | cmd, key_levels
//   out      | out_valid / out_ready  | key_code, pressed_map
//   cfg      | cfg_we                 | cfg_index, cfg_data
//
// Scan request: each key takes a read and a calc state on the key-state RAM
// read/modify/write loop, plus push2 if it queues two codes, then done.
// A pop passes pop, popw (skipped if empty) and done; a clear skips popw.
// One request is in flight at a time; the output register frees the input
// side as soon as a result is loaded. Reset is synchronous; key state reads
// its reset value until a key is first written (per-key valid bits).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_key_debounce_event_fifo #(
  parameter int NUM_KEYS   = mkdef_pkg::NUM_KEYS_DEF,
  parameter int FIFO_DEPTH = mkdef_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mkdef_pkg::CMD_W-1:0]         cmd,
  input  logic [mkdef_pkg::LEVEL_W-1:0]       key_levels,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mkdef_pkg::CODE_W-1:0]        key_code,
  output logic [mkdef_pkg::LEVEL_W-1:0]       pressed_map,
  input  logic                                cfg_we,
  input  logic [mkdef_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mkdef_pkg::CFG_W-1:0]         cfg_data
);

  localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  mkdef_pkg::state_t state;
  mkdef_pkg::state_t state_next;

  logic [mkdef_pkg::FILTER_W-1:0] filter_time;
  logic [mkdef_pkg::LONG_W-1:0]   long_time;
  logic [mkdef_pkg::REPEAT_W-1:0] repeat_speed;

  mkdef_pkg::cmd_t               cmd_r;
  logic [mkdef_pkg::LEVEL_W-1:0] levels_r;
  logic [mkdef_pkg::CODE_W-1:0]  code_r;
  logic [mkdef_pkg::CODE_W-1:0]  code_b_r;

  logic [KEY_W-1:0]    key_idx;
  logic [NUM_KEYS-1:0] key_vld;
  logic [NUM_KEYS-1:0] pressed;
  logic [NUM_KEYS-1:0] levels_ext;

  logic [PTR_W-1:0] write_ptr;
  logic [PTR_W-1:0] read_ptr;
  logic [PTR_W-1:0] second_read_ptr;

  logic                               kram_we;
  logic [mkdef_pkg::KEY_STATE_W-1:0]  kram_q;
  mkdef_pkg::key_state_t              cur_state;
  mkdef_pkg::key_eval_t               res;

  logic                          ev_we;
  logic [PTR_W-1:0]              ev_raddr;
  logic [mkdef_pkg::CODE_W-1:0]  ev_wdata;
  logic [mkdef_pkg::CODE_W-1:0]  ev_q;

  logic                          last_key;
  logic                          pop_empty;
  logic                          out_load;
  logic [mkdef_pkg::LEVEL_W-1:0] map_now;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lvl
    if (k < mkdef_pkg::LEVEL_W) begin : g_in
      assign levels_ext[k] = levels_r[k];
    end else begin : g_none
      assign levels_ext[k] = 1'b0;
    end
  end

  for (genvar j = 0; j < mkdef_pkg::LEVEL_W; j++) begin : g_map
    if (j < NUM_KEYS) begin : g_key
      assign map_now[j] = pressed[j];
    end else begin : g_none
      assign map_now[j] = 1'b0;
    end
  end

  assign cur_state = key_vld[key_idx] ? mkdef_pkg::key_state_t'(kram_q)
                                      : mkdef_pkg::KEY_STATE_RST;

  mkdef_ram #(
    .WIDTH (mkdef_pkg::KEY_STATE_W),
    .DEPTH (NUM_KEYS)
  ) u_key_ram (
    .clk   (clk),
    .we    (kram_we),
    .waddr (key_idx),
    .wdata (res.st),
    .raddr (key_idx),
    .rdata (kram_q)
  );

  mkdef_key_eval u_key_eval (
    .cur          (cur_state),
    .pressed_in   (pressed[key_idx]),
    .level        (levels_ext[key_idx]),
    .key_num      (mkdef_pkg::KEY_IDX_W'(key_idx)),
    .filter_time  (filter_time),
    .long_time    (long_time),
    .repeat_speed (repeat_speed),
    .res          (res)
  );

  mkdef_ram #(
    .WIDTH (mkdef_pkg::CODE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_event_ram (
    .clk   (clk),
    .we    (ev_we),
    .waddr (write_ptr),
    .wdata (ev_wdata),
    .raddr (ev_raddr),
    .rdata (ev_q)
  );

  // Output decode
  always_comb begin
    in_ready  = (state == mkdef_pkg::ST_IDLE);
    kram_we   = (state == mkdef_pkg::ST_CALC);
    ev_we     = ((state == mkdef_pkg::ST_CALC) && res.push_a) ||
                (state == mkdef_pkg::ST_PUSH2);
    ev_wdata  = (state == mkdef_pkg::ST_PUSH2) ? code_b_r : res.code_a;
    ev_raddr  = (cmd_r == mkdef_pkg::CMD_POP2) ? second_read_ptr : read_ptr;
    pop_empty = (ev_raddr == write_ptr);
    last_key  = (key_idx == KEY_W'(NUM_KEYS - 1));
    out_load  = (state == mkdef_pkg::ST_DONE) && (!out_valid || out_ready);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mkdef_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (mkdef_pkg::cmd_t'(cmd))
            mkdef_pkg::CMD_SCAN: state_next = mkdef_pkg::ST_READ;
            mkdef_pkg::CMD_POP, mkdef_pkg::CMD_POP2,
            mkdef_pkg::CMD_CLEAR: state_next = mkdef_pkg::ST_POP;
            default: state_next = mkdef_pkg::ST_IDLE;
          endcase
        end
      end
      mkdef_pkg::ST_READ: state_next = mkdef_pkg::ST_CALC;
      mkdef_pkg::ST_CALC: begin
        if (res.push_b) begin
          state_next = mkdef_pkg::ST_PUSH2;
        end else if (last_key) begin
          state_next = mkdef_pkg::ST_DONE;
        end else begin
          state_next = mkdef_pkg::ST_READ;
        end
      end
      mkdef_pkg::ST_PUSH2: begin
        state_next = last_key ? mkdef_pkg::ST_DONE : mkdef_pkg::ST_READ;
      end
      mkdef_pkg::ST_POP: begin
        if ((cmd_r == mkdef_pkg::CMD_CLEAR) || pop_empty) begin
          state_next = mkdef_pkg::ST_DONE;
        end else begin
          state_next = mkdef_pkg::ST_POPW;
        end
      end
      mkdef_pkg::ST_POPW: state_next = mkdef_pkg::ST_DONE;
      mkdef_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = mkdef_pkg::ST_IDLE;
        end
      end
      default: state_next = mkdef_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= mkdef_pkg::ST_IDLE;
      filter_time     <= mkdef_pkg::FILTER_RST;
      long_time       <= mkdef_pkg::LONG_RST;
      repeat_speed    <= mkdef_pkg::REPEAT_RST;
      key_idx         <= '0;
      key_vld         <= '0;
      pressed         <= '0;
      write_ptr       <= '0;
      read_ptr        <= '0;
      second_read_ptr <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          mkdef_pkg::REG_FILTER_TIME:  filter_time  <= cfg_data[mkdef_pkg::FILTER_W-1:0];
          mkdef_pkg::REG_LONG_TIME:    long_time    <= cfg_data[mkdef_pkg::LONG_W-1:0];
          mkdef_pkg::REG_REPEAT_SPEED: repeat_speed <= cfg_data[mkdef_pkg::REPEAT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        key_idx <= '0;
      end
      if (state == mkdef_pkg::ST_CALC) begin
        key_vld[key_idx] <= 1'b1;
        pressed[key_idx] <= res.pressed;
        if (res.push_a) begin
          write_ptr <= ptr_inc(write_ptr);
        end
        if (!res.push_b && !last_key) begin
          key_idx <= key_idx + 1'b1;
        end
      end
      if (state == mkdef_pkg::ST_PUSH2) begin
        write_ptr <= ptr_inc(write_ptr);
        if (!last_key) begin
          key_idx <= key_idx + 1'b1;
        end
      end
      if ((state == mkdef_pkg::ST_POP) && (cmd_r == mkdef_pkg::CMD_CLEAR)) begin
        read_ptr <= write_ptr;
      end
      if (state == mkdef_pkg::ST_POPW) begin
        if (cmd_r == mkdef_pkg::CMD_POP2) begin
          second_read_ptr <= ptr_inc(second_read_ptr);
        end else begin
          read_ptr <= ptr_inc(read_ptr);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r    <= mkdef_pkg::cmd_t'(cmd);
      levels_r <= key_levels;
      code_r   <= '0;
    end
    if (state == mkdef_pkg::ST_CALC) begin
      code_b_r <= res.code_b;
    end
    if (state == mkdef_pkg::ST_POPW) begin
      code_r <= ev_q;
    end
    if (out_load) begin
      key_code    <= code_r;
      pressed_map <= map_now;
    end
  end

  `ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, state != mkdef_pkg::ST_IDLE)
  `ASSERT_IMPL(a_push2_order, clk, rst, state == mkdef_pkg::ST_PUSH2, $past(state) == mkdef_pkg::ST_CALC)
  `ASSERT_IMPL(a_key_range, clk, rst, (state == mkdef_pkg::ST_READ) || (state == mkdef_pkg::ST_CALC), key_idx <= KEY_W'(NUM_KEYS - 1))
  `ASSERT_NEXT(a_pop_advance, clk, rst, (state == mkdef_pkg::ST_POPW) && (cmd_r == mkdef_pkg::CMD_POP), read_ptr != $past(read_ptr))

endmodule
